@@ hdl/weno_pkg.sv @@
package weno_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int WEIGHT_W   = FRAC_BITS + 1;
  localparam int SMOOTH_W   = 43;
  localparam int EPS_W      = 32;
  localparam int DIFF_W     = SAMPLE_W + 5;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int CHUNK_W    = 22;
  localparam int N_CHUNK    = 4;
  localparam int OP_W       = CHUNK_W * N_CHUNK;
  localparam int WIDE_W     = 2 * OP_W;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int MUL_LAT    = 3;
  localparam int FRONT_LAT  = 5;
  localparam int PIPE_DEPTH = FRONT_LAT + 2 * MUL_LAT + 2 + DIV_STEPS;
  localparam int SM_DELAY   = PIPE_DEPTH - 4;

  localparam int IS_A_GAIN = 13;
  localparam int IS_B_GAIN = 3;
  localparam int LIN_FIRST  = 1;
  localparam int LIN_SECOND = 6;
  localparam int LIN_THIRD  = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic                       mirror;
  } operand_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_first;
    logic [WEIGHT_W-1:0] weight_second;
    logic [WEIGHT_W-1:0] weight_third;
    logic [SMOOTH_W-1:0] smooth_first;
    logic [SMOOTH_W-1:0] smooth_second;
    logic [SMOOTH_W-1:0] smooth_third;
  } result_t;

endpackage

@@ hdl/weno_mul.sv @@
module weno_mul (
  input  logic           clk,
  input  weno_pkg::op_t  a,
  input  weno_pkg::op_t  b,
  output weno_pkg::wide_t p
);
  import weno_pkg::*;

  logic [2*CHUNK_W-1:0] pp [N_CHUNK][N_CHUNK];
  wide_t row      [N_CHUNK];
  wide_t row_next [N_CHUNK];
  wide_t p_next;

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_CHUNK; i++) begin
      for (int j = 0; j < N_CHUNK; j++) begin
        pp[i][j] <= a[i*CHUNK_W +: CHUNK_W] * b[j*CHUNK_W +: CHUNK_W];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N_CHUNK; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < N_CHUNK; j++) begin
        row_next[i] = row_next[i] + (WIDE_W'(pp[i][j]) << (j * CHUNK_W));
      end
    end
  end

  always_comb begin
    p_next = '0;
    for (int i = 0; i < N_CHUNK; i++) begin
      p_next = p_next + (row[i] << (i * CHUNK_W));
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    p   <= p_next;
  end

endmodule

@@ hdl/weno_div.sv @@
module weno_div (
  input  logic                                  clk,
  input  weno_pkg::wide_t [2:0]                 num,
  input  weno_pkg::wide_t                       den,
  output logic [2:0][weno_pkg::WEIGHT_W-1:0]    quot
);
  import weno_pkg::*;

  wide_t [2:0]                rem [DIV_STEPS];
  wide_t                      dn  [DIV_STEPS];
  logic  [2:0][WEIGHT_W-1:0]  qt  [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    wide_t [2:0]               r_in;
    wide_t                     d_in;
    logic  [2:0][WEIGHT_W-1:0] q_in;
    wide_t [2:0]               trial;
    logic  [2:0]               ge;

    if (s == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign d_in = dn[s-1];
      assign q_in = qt[s-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = (s == 0) ? r_in[k] : {r_in[k][WIDE_W-2:0], 1'b0};
        ge[k]    = trial[k] >= d_in;
      end
    end

    always_ff @(posedge clk) begin
      dn[s] <= d_in;
      for (int k = 0; k < 3; k++) begin
        rem[s][k] <= ge[k] ? trial[k] - d_in : trial[k];
        qt[s][k]  <= {q_in[k][WEIGHT_W-2:0], ge[k]};
      end
    end
  end

  assign quot = qt[DIV_STEPS-1];

endmodule

@@ hdl/weno_smoothness_weights.sv @@
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the front stages, two 3-stage wide multipliers, the numerator and denominator
// registers and the 17-step quotient pipeline. Reset clears the valid pipeline and sets eps to 1.
// The receiver cannot stall; each result is shown for exactly one cycle.
module weno_smoothness_weights (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  weno_pkg::operand_t                 operand,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [weno_pkg::EPS_W-1:0]         cfg_data,
  output logic                               result_valid,
  output weno_pkg::result_t                  result
);
  import weno_pkg::*;

  logic [EPS_W-1:0]      eps;
  logic [EPS_W-1:0]      eps_eff;
  logic [PIPE_DEPTH-1:0] vld;

  logic signed [SAMPLE_W-1:0] raw [6];
  logic signed [DIFF_W-1:0]   s   [6];
  logic signed [DIFF_W-1:0]   av  [3];
  logic signed [DIFF_W-1:0]   bv  [3];
  logic [SQ_W-1:0]            sqa [3];
  logic [SQ_W-1:0]            sqb [3];
  logic [SMOOTH_W-1:0]        sm  [3];
  logic [SMOOTH_W-1:0]        dd  [3];
  logic [SMOOTH_W-1:0]        smp [SM_DELAY][3];
  wide_t                      m   [3];
  wide_t                      n   [3];
  wide_t [2:0]                nm;
  wide_t [2:0]                nmd;
  wide_t                      den;
  logic [2:0][WEIGHT_W-1:0]   quot;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign eps_eff   = (eps == '0) ? EPS_W'(1) : eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_W'(1);
      vld <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        eps <= cfg_data;
      end
      vld <= {vld[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  assign raw[0] = operand.sample_0;
  assign raw[1] = operand.sample_1;
  assign raw[2] = operand.sample_2;
  assign raw[3] = operand.sample_3;
  assign raw[4] = operand.sample_4;
  assign raw[5] = operand.sample_5;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      s[k] <= DIFF_W'(operand.mirror ? raw[5-k] : raw[k]);
    end

    av[0] <= DIFF_W'(-s[0] + 3 * s[1] - 3 * s[2] + s[3]);
    bv[0] <= DIFF_W'(-s[0] + 5 * s[1] - 7 * s[2] + 3 * s[3]);
    av[1] <= DIFF_W'(-s[1] + 3 * s[2] - 3 * s[3] + s[4]);
    bv[1] <= DIFF_W'(-s[1] + s[2] + s[3] - s[4]);
    av[2] <= DIFF_W'(-s[2] + 3 * s[3] - 3 * s[4] + s[5]);
    bv[2] <= DIFF_W'(-3 * s[2] + 7 * s[3] - 5 * s[4] + s[5]);

    for (int k = 0; k < 3; k++) begin
      sqa[k] <= $unsigned(SQ_W'(av[k]) * SQ_W'(av[k]));
      sqb[k] <= $unsigned(SQ_W'(bv[k]) * SQ_W'(bv[k]));
      sm[k]  <= SMOOTH_W'(sqa[k]) * SMOOTH_W'(IS_A_GAIN)
              + SMOOTH_W'(sqb[k]) * SMOOTH_W'(IS_B_GAIN);
      dd[k]  <= sm[k] + SMOOTH_W'(eps_eff);
    end

    smp[0] <= sm;
    for (int t = 1; t < SM_DELAY; t++) begin
      smp[t] <= smp[t-1];
    end

    nm[0] <= n[0] * WIDE_W'(LIN_FIRST);
    nm[1] <= n[1] * WIDE_W'(LIN_SECOND);
    nm[2] <= n[2] * WIDE_W'(LIN_THIRD);
    den   <= nm[0] + nm[1] + nm[2];
    nmd   <= nm;
  end

  // products of the other two denominators, then squared
  weno_mul u_mul_m0 (.clk(clk), .a(OP_W'(dd[1])), .b(OP_W'(dd[2])), .p(m[0]));
  weno_mul u_mul_m1 (.clk(clk), .a(OP_W'(dd[0])), .b(OP_W'(dd[2])), .p(m[1]));
  weno_mul u_mul_m2 (.clk(clk), .a(OP_W'(dd[0])), .b(OP_W'(dd[1])), .p(m[2]));

  weno_mul u_mul_n0 (.clk(clk), .a(m[0][OP_W-1:0]), .b(m[0][OP_W-1:0]), .p(n[0]));
  weno_mul u_mul_n1 (.clk(clk), .a(m[1][OP_W-1:0]), .b(m[1][OP_W-1:0]), .p(n[1]));
  weno_mul u_mul_n2 (.clk(clk), .a(m[2][OP_W-1:0]), .b(m[2][OP_W-1:0]), .p(n[2]));

  weno_div u_div (
    .clk  (clk),
    .num  (nmd),
    .den  (den),
    .quot (quot)
  );

  assign result_valid         = vld[PIPE_DEPTH-1];
  assign result.weight_first  = quot[0];
  assign result.weight_second = quot[1];
  assign result.weight_third  = quot[2];
  assign result.smooth_first  = smp[SM_DELAY-1][0];
  assign result.smooth_second = smp[SM_DELAY-1][1];
  assign result.smooth_third  = smp[SM_DELAY-1][2];

endmodule

@@ tb/weno_smoothness_weights_test.sv @@
`timescale 1ns / 100ps

module weno_smoothness_weights_test;
  import weno_pkg::*;

  localparam int TOTAL_ITEMS = 1450;
  localparam int SETTLE      = 40;

  typedef struct {
    bit                 is_cfg;
    logic [EPS_W-1:0]   eps;
    operand_t           op;
  } job_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  operand_t          operand;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [EPS_W-1:0]  cfg_data;
  logic              result_valid;
  result_t           result;

  job_t              jobs_q[$];
  result_t           expected_q[$];
  logic [EPS_W-1:0]  eps_cur;
  int                gap_cnt;
  int                quiet_cnt;
  int                sent;
  bit                failed;

  weno_smoothness_weights uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand(operand),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t weights_of(operand_t op, logic [EPS_W-1:0] eps);
    logic signed [SAMPLE_W-1:0] raw[6];
    longint     s[6];
    longint     a[3];
    longint     b[3];
    logic [63:0]  sm[3];
    logic [255:0] e;
    logic [255:0] dk;
    logic [255:0] q[3];
    logic [255:0] n[3];
    logic [255:0] total;
    logic [255:0] w[3];
    result_t      r;
    raw = '{op.sample_0, op.sample_1, op.sample_2, op.sample_3, op.sample_4, op.sample_5};
    for (int k = 0; k < 6; k++) s[k] = op.mirror ? raw[5-k] : raw[k];
    a[0] = -s[0] + 3*s[1] - 3*s[2] + s[3];
    b[0] = -s[0] + 5*s[1] - 7*s[2] + 3*s[3];
    a[1] = -s[1] + 3*s[2] - 3*s[3] + s[4];
    b[1] = -s[1] + s[2] + s[3] - s[4];
    a[2] = -s[2] + 3*s[3] - 3*s[4] + s[5];
    b[2] = -3*s[2] + 7*s[3] - 5*s[4] + s[5];
    e = (eps == '0) ? 256'd1 : 256'(eps);
    for (int k = 0; k < 3; k++) begin
      sm[k] = IS_A_GAIN * a[k] * a[k] + IS_B_GAIN * b[k] * b[k];
      dk = e + 256'(sm[k]);
      q[k] = dk * dk;
    end
    n[0] = q[1] * q[2] * LIN_FIRST;
    n[1] = q[0] * q[2] * LIN_SECOND;
    n[2] = q[0] * q[1] * LIN_THIRD;
    total = n[0] + n[1] + n[2];
    for (int k = 0; k < 3; k++) w[k] = (n[k] << FRAC_BITS) / total;
    r.weight_first  = w[0][WEIGHT_W-1:0];
    r.weight_second = w[1][WEIGHT_W-1:0];
    r.weight_third  = w[2][WEIGHT_W-1:0];
    r.smooth_first  = sm[0][SMOOTH_W-1:0];
    r.smooth_second = sm[1][SMOOTH_W-1:0];
    r.smooth_third  = sm[2][SMOOTH_W-1:0];
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample(int mode, int base);
    case (mode)
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'(base + $urandom_range(0, 8) - 4);
      2: return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic operand_t rand_stencil();
    operand_t op;
    int       mode;
    int       base;
    int       slope;
    logic [SAMPLE_W-1:0] v[6];
    mode  = $urandom_range(0, 9);
    base  = $urandom_range(0, 60000) - 30000;
    slope = $urandom_range(0, 400) - 200;
    for (int k = 0; k < 6; k++) begin
      if (mode < 3) v[k] = rand_sample(0, 0);
      else if (mode < 6) v[k] = rand_sample(1, base + slope * k);
      else if (mode < 8) v[k] = rand_sample(2, 0);
      else if (mode == 8) v[k] = rand_sample($urandom_range(0, 3), base);
      else v[k] = rand_sample(3, 0);
    end
    if ($urandom_range(0, 5) == 0) v[$urandom_range(0, 5)] = SAMPLE_W'($urandom);
    op = '{v[0], v[1], v[2], v[3], v[4], v[5], 1'($urandom)};
    return op;
  endfunction

  task automatic add_item(operand_t op);
    job_t j;
    j.is_cfg = 1'b0;
    j.eps = '0;
    j.op = op;
    jobs_q.push_back(j);
  endtask

  task automatic add_cfg(logic [EPS_W-1:0] eps);
    job_t j;
    j.is_cfg = 1'b1;
    j.eps = eps;
    j.op = '0;
    jobs_q.push_back(j);
  endtask

  task automatic add_random(int count);
    for (int i = 0; i < count; i++) add_item(rand_stencil());
  endtask

  always @(posedge clk) begin
    job_t j;
    if (rst) begin
      start <= 1'b0;
      operand <= '0;
      cfg_valid <= 1'b0;
      cfg_data <= '0;
      eps_cur <= 32'd1;
      gap_cnt <= 0;
      quiet_cnt <= 0;
      sent <= 0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(weights_of(operand, eps_cur));
        sent <= sent + 1;
      end
      if (cfg_valid && cfg_ready) eps_cur <= cfg_data;
      quiet_cnt <= (expected_q.size() == 0 && !(start && !busy)) ? quiet_cnt + 1 : 0;

      if (cfg_valid && !cfg_ready) begin
        cfg_valid <= 1'b1;
      end else if (start && busy) begin
        start <= 1'b1;
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (jobs_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (jobs_q[0].is_cfg) begin
        start <= 1'b0;
        if (quiet_cnt >= SETTLE && !cfg_valid) begin
          j = jobs_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_data <= j.eps;
        end else begin
          cfg_valid <= 1'b0;
        end
      end else if (sent < TOTAL_ITEMS - 200 && $urandom_range(0, 5) == 0) begin
        gap_cnt <= $urandom_range(0, 3);
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        j = jobs_q.pop_front();
        start <= 1'b1;
        operand <= j.op;
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (result.weight_first !== exp_r.weight_first) begin
          $error("weight_first exp %0d got %0d", exp_r.weight_first, result.weight_first);
          failed = 1'b1;
        end
        if (result.weight_second !== exp_r.weight_second) begin
          $error("weight_second exp %0d got %0d", exp_r.weight_second, result.weight_second);
          failed = 1'b1;
        end
        if (result.weight_third !== exp_r.weight_third) begin
          $error("weight_third exp %0d got %0d", exp_r.weight_third, result.weight_third);
          failed = 1'b1;
        end
        if (result.smooth_first !== exp_r.smooth_first) begin
          $error("smooth_first exp %0d got %0d", exp_r.smooth_first, result.smooth_first);
          failed = 1'b1;
        end
        if (result.smooth_second !== exp_r.smooth_second) begin
          $error("smooth_second exp %0d got %0d", exp_r.smooth_second, result.smooth_second);
          failed = 1'b1;
        end
        if (result.smooth_third !== exp_r.smooth_third) begin
          $error("smooth_third exp %0d got %0d", exp_r.smooth_third, result.smooth_third);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    operand_t op;
    rst = 1'b1;

    // directed: flat, extremes, alternating, spikes, mirror both ways
    add_item('0);
    add_item('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0});
    add_item('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1});
    add_item('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0});
    add_item('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1});
    add_item('{16'hffff, 16'h0000, 16'h5555, 16'haaaa, 16'h0001, 16'h8001, 1'b0});
    add_item('{16'hffff, 16'h0000, 16'h5555, 16'haaaa, 16'h0001, 16'h8001, 1'b1});
    for (int p = 0; p < 6; p++) begin
      op = '0;
      op.mirror = p[0];
      case (p)
        0: op.sample_0 = 16'h7fff;
        1: op.sample_1 = 16'h8000;
        2: op.sample_2 = 16'h7fff;
        3: op.sample_3 = 16'h8000;
        4: op.sample_4 = 16'h7fff;
        default: op.sample_5 = 16'h8000;
      endcase
      add_item(op);
    end
    add_item('{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 1'b0});
    add_item('{16'd0, 16'd1, 16'd4, 16'd9, 16'd16, 16'd25, 1'b1});
    add_item('{16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0});
    add_item('{16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1});

    add_cfg(32'd0);
    add_item('{16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 1'b0});
    add_item('0);
    add_random(290);
    add_cfg(32'hffff_ffff);
    add_item('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1});
    add_random(280);
    add_cfg(32'($urandom_range(1, 1000)));
    add_random(280);
    add_cfg($urandom);
    add_random(280);
    add_cfg(32'd1);
    add_random(280);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (jobs_q.size() != 0 || start || cfg_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("weno_smoothness_weights: match");
    end else begin
      $display("weno_smoothness_weights: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("weno_smoothness_weights: mismatch");
    $finish;
  end

endmodule
